FILE: rtl/ukol_pkg.sv
// Shared types and constants of the unique-key ordered list.
// Holds the opcode, state and walk-mode enums, the entry layout and the
// command and status groups between the controller and the datapath.
`timescale 1ns / 1ps

package ukol_pkg;

   // List depth and derived index and count widths.
   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Fixed field widths of the transactions.
   localparam int FUNC_W      = 3;
   localparam int WORD_W      = 32;
   localparam int POS_W       = 6;
   localparam int COUNT_OUT_W = 7;
   localparam int CMP_W       = (POS_W > CNT_W) ? POS_W : CNT_W;

   // Packed payload widths, rounded up to whole bytes.
   localparam int REQ_FIELDS_W = 5 * WORD_W + POS_W + 1;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + COUNT_OUT_W + 5 * WORD_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Operation codes carried in the request tuser.
   typedef enum logic [FUNC_W-1:0] {
      FN_APPEND    = 3'd0,
      FN_REMOVE    = 3'd1,
      FN_CONTAINS  = 3'd2,
      FN_READ      = 3'd3,
      FN_SET_FLAG  = 3'd4,
      FN_CLR_FLAGS = 3'd5,
      FN_CLEAR     = 3'd6,
      FN_COUNT     = 3'd7
   } func_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_FLAGS,
      ST_READ,
      ST_SETFLAG,
      ST_RESP
   } state_type;

   // What the entry walker does on each step.
   typedef enum logic [1:0] {
      WALK_SEARCH,
      WALK_SHIFT,
      WALK_FLAGS
   } walk_mode_type;

   // One stored entry, without its failed flag.
   typedef struct packed {
      logic [WORD_W-1:0] slug;
      logic [WORD_W-1:0] file;
      logic [WORD_W-1:0] title;
      logic [WORD_W-1:0] platform;
      logic [WORD_W-1:0] key;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          latch;
      logic          walk_start;
      logic          walk_from_hit;
      logic          walk_run;
      walk_mode_type walk_mode;
      logic          append_wr;
      logic          flag_wr;
      logic          read_en;
      logic          cnt_inc;
      logic          cnt_dec;
      logic          cnt_clr;
      logic          load_rsp;
      logic          ok;
      logic          entry_sel;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;
      logic walk_done;
      logic full;
      logic pos_ok;
      logic rsp_free;
   } dp_stat_type;

endpackage

FILE: rtl/ukol_dpath.sv
// Datapath of the unique-key ordered list: entry memories, fill count,
// entry walker, request latch and result register.
// Depends on ukol_pkg.
`timescale 1ns / 1ps

module ukol_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  ukol_pkg::dp_cmd_type          cmd,
   output ukol_pkg::dp_stat_type         stat,
   input  logic [ukol_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ukol_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ukol_pkg::*;

   // Entry storage; the failed flags live in their own memory.
   entry_type   pay_mem [DEPTH];
   logic        fail_mem [DEPTH];
   entry_type   pay_rdata_ff;
   logic        fail_rdata_ff;

   // Latched request fields.
   entry_type          req_entry_ff;
   logic [POS_W-1:0]   pos_ff;
   logic               flag_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic [CNT_W-1:0]   cmp_ff, cmp_in;
   logic               dvalid_ff, dvalid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   entry_type          rsp_entry_ff;
   logic               rsp_failed_ff;

   logic               walk_go;
   logic               walk_rd;
   logic               shift_we;
   logic               flags_we;
   logic [CNT_W-1:0]   prev_idx;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               pay_we;
   logic [IDX_W-1:0]   pay_waddr;
   entry_type          pay_wdata;
   logic               fail_we;
   logic [IDX_W-1:0]   fail_waddr;
   logic               fail_wdata;

   // Latch the request payload when a transaction is taken.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_entry_ff.key      <= req_tdata[WORD_W-1:0];
         req_entry_ff.platform <= req_tdata[2*WORD_W-1:WORD_W];
         req_entry_ff.title    <= req_tdata[3*WORD_W-1:2*WORD_W];
         req_entry_ff.file     <= req_tdata[4*WORD_W-1:3*WORD_W];
         req_entry_ff.slug     <= req_tdata[5*WORD_W-1:4*WORD_W];
         pos_ff                <= req_tdata[5*WORD_W+POS_W-1:5*WORD_W];
         flag_ff               <= req_tdata[5*WORD_W+POS_W];
      end
   end

   // The walker issues one read per step; the data returns in the cycle after.
   assign walk_go  = cmd.walk_run && (issue_ff < count_ff);
   assign walk_rd  = walk_go && (cmd.walk_mode != WALK_FLAGS);
   assign shift_we = cmd.walk_run && (cmd.walk_mode == WALK_SHIFT) && dvalid_ff;
   assign flags_we = walk_go && (cmd.walk_mode == WALK_FLAGS);
   assign prev_idx = cmp_ff - CNT_W'(1);

   always_comb begin
      issue_in  = issue_ff;
      cmp_in    = cmp_ff;
      dvalid_in = dvalid_ff;
      if (cmd.walk_start) begin
         issue_in  = cmd.walk_from_hit ? (cmp_ff + CNT_W'(1)) : '0;
         dvalid_in = 1'b0;
      end else if (cmd.walk_run) begin
         if (walk_go) begin
            issue_in = issue_ff + CNT_W'(1);
            cmp_in   = issue_ff;
         end
         dvalid_in = walk_rd;
      end
   end

   // Fill count update.
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Memory port selection.
   assign rd_en   = walk_rd || cmd.read_en;
   assign rd_addr = cmd.read_en ? IDX_W'(pos_ff) : issue_ff[IDX_W-1:0];

   assign pay_we    = shift_we || cmd.append_wr;
   assign pay_waddr = cmd.append_wr ? count_ff[IDX_W-1:0] : prev_idx[IDX_W-1:0];
   assign pay_wdata = cmd.append_wr ? req_entry_ff : pay_rdata_ff;

   assign fail_we = shift_we || cmd.append_wr || cmd.flag_wr || flags_we;

   always_comb begin
      fail_waddr = prev_idx[IDX_W-1:0];
      fail_wdata = fail_rdata_ff;
      if (cmd.append_wr) begin
         fail_waddr = count_ff[IDX_W-1:0];
         fail_wdata = 1'b0;
      end else if (cmd.flag_wr) begin
         fail_waddr = IDX_W'(pos_ff);
         fail_wdata = flag_ff;
      end else if (flags_we) begin
         fail_waddr = issue_ff[IDX_W-1:0];
         fail_wdata = 1'b0;
      end
   end

   // Entry memories with registered read data.
   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[pay_waddr] <= pay_wdata;
      end
      if (rd_en) begin
         pay_rdata_ff <= pay_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem[fail_waddr] <= fail_wdata;
      end
      if (rd_en) begin
         fail_rdata_ff <= fail_mem[rd_addr];
      end
   end

   // Control registers of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      cmp_ff   <= cmp_in;
   end

   // Result register; it holds a transaction until the sink takes it.
   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ok_ff     <= cmd.ok;
         rsp_count_ff  <= COUNT_OUT_W'(count_ff);
         rsp_entry_ff  <= cmd.entry_sel ? pay_rdata_ff : '0;
         rsp_failed_ff <= cmd.entry_sel ? fail_rdata_ff : 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_failed_ff,
                        rsp_entry_ff.slug, rsp_entry_ff.file, rsp_entry_ff.title,
                        rsp_entry_ff.platform, rsp_entry_ff.key,
                        rsp_count_ff, rsp_ok_ff};

   // Status toward the controller.
   assign stat.hit       = dvalid_ff && (pay_rdata_ff.key == req_entry_ff.key);
   assign stat.walk_done = !dvalid_ff && !(issue_ff < count_ff);
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.pos_ok    = (CMP_W'(pos_ff) < CMP_W'(count_ff));
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

endmodule

FILE: rtl/ukol_ctrl.sv
// Controller of the unique-key ordered list: sequences each operation
// and drives the datapath through the command and status groups.
// Depends on ukol_pkg.
`timescale 1ns / 1ps

module ukol_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ukol_pkg::FUNC_W-1:0] req_func,
   input  ukol_pkg::dp_stat_type       stat,
   output ukol_pkg::dp_cmd_type        cmd
);
   import ukol_pkg::*;

   state_type state_ff, state_in;
   func_type  op_ff, op_in;
   func_type  req_op;
   logic      ok_ff, ok_in;
   logic      sel_ff, sel_in;

   assign req_op = func_type'(req_func);

   // Next state, with the result flags that go along with it.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      ok_in    = ok_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_op;
               sel_in = 1'b0;
               ok_in  = 1'b1;
               case (req_op)
                  FN_APPEND: begin
                     if (stat.full) begin
                        ok_in    = 1'b0;
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  FN_REMOVE, FN_CONTAINS: state_in = ST_SEARCH;
                  FN_READ:                state_in = ST_READ;
                  FN_SET_FLAG:            state_in = ST_SETFLAG;
                  FN_CLR_FLAGS:           state_in = ST_FLAGS;
                  default:                state_in = ST_RESP;
               endcase
            end
         end
         ST_SEARCH: begin
            if (stat.hit) begin
               if (op_ff == FN_REMOVE) begin
                  state_in = ST_SHIFT;
               end else begin
                  ok_in    = (op_ff == FN_CONTAINS);
                  state_in = ST_RESP;
               end
            end else if (stat.walk_done) begin
               ok_in    = (op_ff == FN_APPEND);
               state_in = ST_RESP;
            end
         end
         ST_SHIFT, ST_FLAGS: begin
            if (stat.walk_done) begin
               ok_in    = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            ok_in    = stat.pos_ok;
            sel_in   = stat.pos_ok;
            state_in = ST_RESP;
         end
         ST_SETFLAG: begin
            ok_in    = stat.pos_ok;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands for the current state.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.latch      = req_tvalid;
            cmd.walk_start = req_tvalid;
            cmd.cnt_clr    = req_tvalid && (req_op == FN_CLEAR);
         end
         ST_SEARCH: begin
            cmd.walk_run  = 1'b1;
            cmd.walk_mode = WALK_SEARCH;
            if (stat.hit) begin
               if (op_ff == FN_REMOVE) begin
                  cmd.walk_start    = 1'b1;
                  cmd.walk_from_hit = 1'b1;
               end
            end else if (stat.walk_done && (op_ff == FN_APPEND)) begin
               cmd.append_wr = 1'b1;
               cmd.cnt_inc   = 1'b1;
            end
         end
         ST_SHIFT: begin
            cmd.walk_run  = 1'b1;
            cmd.walk_mode = WALK_SHIFT;
            cmd.cnt_dec   = stat.walk_done;
         end
         ST_FLAGS: begin
            cmd.walk_run  = 1'b1;
            cmd.walk_mode = WALK_FLAGS;
         end
         ST_READ:    cmd.read_en = stat.pos_ok;
         ST_SETFLAG: cmd.flag_wr = stat.pos_ok;
         ST_RESP: begin
            cmd.load_rsp  = stat.rsp_free;
            cmd.ok        = ok_ff;
            cmd.entry_sel = sel_ff;
         end
         default: cmd = '0;
      endcase
   end

   // Controller registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= FN_COUNT;
         ok_ff    <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         ok_ff    <= ok_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

FILE: rtl/unique_key_ordered_list.sv
// Ordered list of up to DEPTH entries with unique keys, with compaction on
// remove. The list takes one request transaction at a time. An append, remove
// or contains walks the stored keys through a single memory read port, one
// entry per cycle, and an append or contains stops early when the key is found.
// A remove that finds its key walks the later entries once more to shift them
// down. Clear flags sweeps the flag memory. A finished result waits in an output
// register, and the next request is taken while it waits. There is no clearing
// pass after reset: the fill count alone marks which entries hold data. Depends
// on ukol_pkg, ukol_ctrl and ukol_dpath.
`timescale 1ns / 1ps

module unique_key_ordered_list (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0: key, platform_in, title_handle, file_handle,
   // slug_handle, position, flag_value, zero fill.
   input  logic [ukol_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: func.
   input  logic [ukol_pkg::FUNC_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0: ok, count_out, key_out, platform_out, title_out,
   // file_out, slug_out, failed_out, zero fill.
   output logic [ukol_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ukol_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer for every operation.
   ukol_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Storage, walker and result register.
   ukol_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: sim/unique_key_ordered_list_test.sv
// Self-checking testbench for the unique-key ordered list: drives request
// transactions, predicts each response with its own copy of the list and
// compares every response field. Depends on ukol_pkg and unique_key_ordered_list.
`timescale 1ns / 1ps

module unique_key_ordered_list_test;
   import ukol_pkg::*;

   localparam logic [WORD_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic [WORD_W-1:0] KEY_MAX = 32'h7fff_ffff;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAX_REPORTS  = 10;
   localparam int POOL_SIZE    = 32;

   // One request transaction; the fields below op pack straight into tdata.
   typedef struct packed {
      func_type           op;
      logic               flag;
      logic [POS_W-1:0]   position;
      logic [WORD_W-1:0]  slug;
      logic [WORD_W-1:0]  file;
      logic [WORD_W-1:0]  title;
      logic [WORD_W-1:0]  platform;
      logic [WORD_W-1:0]  key;
   } list_request_t;

   // One response transaction, laid out as in rsp_tdata with ok at bit 0.
   typedef struct packed {
      logic                   failed;
      logic [WORD_W-1:0]      slug;
      logic [WORD_W-1:0]      file;
      logic [WORD_W-1:0]      title;
      logic [WORD_W-1:0]      platform;
      logic [WORD_W-1:0]      key;
      logic [COUNT_OUT_W-1:0] count;
      logic                   ok;
   } list_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // Fields from bit 0: key, platform_in, title_handle, file_handle,
   // slug_handle, position, flag_value, zero fill.
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // Fields from bit 0: func.
   logic [FUNC_W-1:0]     req_tuser = FN_COUNT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // Fields from bit 0: ok, count_out, key_out, platform_out, title_out,
   // file_out, slug_out, failed_out, zero fill.
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predicted list contents.
   entry_type list_entries [DEPTH];
   logic      list_failed  [DEPTH];
   int        list_count = 0;

   list_result_t pending_results [$];
   logic [WORD_W-1:0] key_pool [POOL_SIZE];

   int  mismatch_count = 0;
   int  result_index = 0;
   int  cycle_count = 0;
   bit  tx_idle_on = 1'b1;
   bit  rx_idle_on = 1'b1;
   int  rsp_hold_request = 0;
   int  rsp_hold_left = 0;
   int  rsp_stall_left = 0;

   unique_key_ordered_list dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("FAIL");
         $finish;
      end
   end

   // Index of the first entry holding the key, or the count when absent.
   function automatic int find_in_list(logic [WORD_W-1:0] k);
      for (int i = 0; i < list_count; i++)
         if (list_entries[i].key == k)
            return i;
      return list_count;
   endfunction

   // Applies one request to the predicted list and returns its response.
   function automatic list_result_t apply_to_list(list_request_t rq);
      list_result_t rs;
      int hit;
      rs = '0;
      hit = find_in_list(rq.key);
      case (rq.op)
         FN_APPEND: begin
            if (list_count < DEPTH && hit == list_count) begin
               list_entries[list_count].key      = rq.key;
               list_entries[list_count].platform = rq.platform;
               list_entries[list_count].title    = rq.title;
               list_entries[list_count].file     = rq.file;
               list_entries[list_count].slug     = rq.slug;
               list_failed[list_count] = 1'b0;
               list_count++;
               rs.ok = 1'b1;
            end
         end
         FN_REMOVE: begin
            // Later entries move down one place to close the gap.
            if (hit < list_count) begin
               for (int i = hit; i + 1 < list_count; i++) begin
                  list_entries[i] = list_entries[i + 1];
                  list_failed[i]  = list_failed[i + 1];
               end
               list_count--;
               rs.ok = 1'b1;
            end
         end
         FN_CONTAINS: rs.ok = (hit < list_count);
         FN_READ: begin
            if (int'(rq.position) < list_count) begin
               rs.ok       = 1'b1;
               rs.key      = list_entries[rq.position].key;
               rs.platform = list_entries[rq.position].platform;
               rs.title    = list_entries[rq.position].title;
               rs.file     = list_entries[rq.position].file;
               rs.slug     = list_entries[rq.position].slug;
               rs.failed   = list_failed[rq.position];
            end
         end
         FN_SET_FLAG: begin
            if (int'(rq.position) < list_count) begin
               list_failed[rq.position] = rq.flag;
               rs.ok = 1'b1;
            end
         end
         FN_CLR_FLAGS: begin
            for (int i = 0; i < list_count; i++)
               list_failed[i] = 1'b0;
            rs.ok = 1'b1;
         end
         FN_CLEAR: begin
            list_count = 0;
            rs.ok = 1'b1;
         end
         default: rs.ok = 1'b1;
      endcase
      rs.count = COUNT_OUT_W'(list_count);
      return rs;
   endfunction

   // Request with the given key, position and flag and random payload handles.
   function automatic list_request_t make_request(func_type op, logic [WORD_W-1:0] k,
                                                  logic [POS_W-1:0] pos, logic flag);
      list_request_t rq;
      rq.op       = op;
      rq.key      = k;
      rq.position = pos;
      rq.flag     = flag;
      rq.platform = $urandom;
      rq.title    = $urandom;
      rq.file     = $urandom;
      rq.slug     = $urandom;
      return rq;
   endfunction

   // Keys mostly come from a small pool or the list itself so that hits,
   // duplicates and removes happen often.
   function automatic logic [WORD_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 45)
         return key_pool[$urandom_range(POOL_SIZE - 1, 0)];
      if (roll < 75 && list_count > 0)
         return list_entries[$urandom_range(list_count - 1, 0)].key;
      return $urandom;
   endfunction

   // Positions mostly name live entries, sometimes the boundary or anything.
   function automatic logic [POS_W-1:0] pick_position();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 75 && list_count > 0)
         return POS_W'($urandom_range(list_count - 1, 0));
      if (roll < 85 && list_count < DEPTH)
         return POS_W'(list_count);
      return POS_W'($urandom_range(63, 0));
   endfunction

   function automatic list_request_t random_request();
      int roll;
      func_type op;
      roll = $urandom_range(99, 0);
      if (roll < 30)      op = FN_APPEND;
      else if (roll < 44) op = FN_REMOVE;
      else if (roll < 58) op = FN_CONTAINS;
      else if (roll < 74) op = FN_READ;
      else if (roll < 86) op = FN_SET_FLAG;
      else if (roll < 90) op = FN_CLR_FLAGS;
      else if (roll < 92) op = FN_CLEAR;
      else                op = FN_COUNT;
      return make_request(op, pick_key(), pick_position(), 1'($urandom_range(1, 0)));
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 75) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(30, 10);
   endfunction

   // Offers one request until accepted, then records its expected response.
   task automatic send_request(list_request_t rq);
      logic [REQ_DATA_W-1:0] payload;
      int gap;
      payload = '0;
      payload[REQ_FIELDS_W-1:0] = rq[REQ_FIELDS_W-1:0];
      req_tdata  <= payload;
      req_tuser  <= rq.op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_results.push_back(apply_to_list(rq));
      gap = tx_idle_on ? draw_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits for every outstanding response.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("response %0d: %s", result_index, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [WORD_W-1:0] got,
                              logic [WORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s expected %h got %h", name, want, got));
   endtask

   // Response ready: random stalls, plus a long hold when a test asks for one.
   always @(posedge clock) begin : drive_rsp_ready
      int roll;
      if (rsp_hold_request > 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (!rx_idle_on) begin
         rsp_tready <= 1'b1;
      end else begin
         roll = $urandom_range(99, 0);
         if (roll < 80) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rsp_stall_left = (roll < 96) ? $urandom_range(2, 0) : $urandom_range(40, 10);
         end
      end
   end

   // Compares each accepted response with the oldest expectation.
   always @(posedge clock) begin : check_responses
      list_result_t got;
      list_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_FIELDS_W-1:0];
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", got));
         end else begin
            want = pending_results.pop_front();
            check_field("ok", 32'(got.ok), 32'(want.ok));
            check_field("count_out", 32'(got.count), 32'(want.count));
            check_field("key_out", got.key, want.key);
            check_field("platform_out", got.platform, want.platform);
            check_field("title_out", got.title, want.title);
            check_field("file_out", got.file, want.file);
            check_field("slug_out", got.slug, want.slug);
            check_field("failed_out", 32'(got.failed), 32'(want.failed));
         end
         result_index++;
      end
   end

   // Every operation on an empty and a small list, field extremes included.
   task automatic test_directed_ops();
      list_request_t rq;
      send_request(make_request(FN_COUNT, '0, '0, 1'b0));
      send_request(make_request(FN_READ, '0, '0, 1'b0));
      send_request(make_request(FN_SET_FLAG, '0, '0, 1'b1));
      send_request(make_request(FN_REMOVE, 32'd5, '0, 1'b0));
      send_request(make_request(FN_CONTAINS, 32'd5, '0, 1'b0));
      send_request(make_request(FN_CLR_FLAGS, '0, '0, 1'b0));
      rq = make_request(FN_APPEND, KEY_MIN, '1, 1'b1);
      rq.platform = KEY_MAX;
      rq.title = '1;
      rq.file  = '1;
      rq.slug  = '1;
      send_request(rq);
      rq = make_request(FN_APPEND, KEY_MAX, '0, 1'b0);
      rq.platform = KEY_MIN;
      rq.title = '0;
      rq.file  = '0;
      rq.slug  = '0;
      send_request(rq);
      send_request(make_request(FN_APPEND, '0, '0, 1'b0));
      send_request(make_request(FN_APPEND, '1, '1, 1'b1));
      // A duplicate key is rejected.
      send_request(make_request(FN_APPEND, KEY_MAX, '0, 1'b0));
      send_request(make_request(FN_CONTAINS, KEY_MIN, '0, 1'b0));
      send_request(make_request(FN_READ, '0, 6'd3, 1'b0));
      send_request(make_request(FN_READ, '0, 6'd4, 1'b0));
      send_request(make_request(FN_SET_FLAG, '0, 6'd1, 1'b1));
      send_request(make_request(FN_SET_FLAG, '0, '1, 1'b1));
      send_request(make_request(FN_READ, '0, 6'd1, 1'b0));
      // Removing the head shifts the flagged entry down.
      send_request(make_request(FN_REMOVE, KEY_MIN, '0, 1'b0));
      send_request(make_request(FN_READ, '0, 6'd0, 1'b0));
      send_request(make_request(FN_CLR_FLAGS, '0, '0, 1'b0));
      send_request(make_request(FN_READ, '0, 6'd0, 1'b0));
      send_request(make_request(FN_REMOVE, '1, '0, 1'b0));
      send_request(make_request(FN_COUNT, '0, '0, 1'b0));
      send_request(make_request(FN_CLEAR, '0, '0, 1'b0));
      send_request(make_request(FN_READ, '0, 6'd0, 1'b0));
      send_request(make_request(FN_CONTAINS, '0, '0, 1'b0));
   endtask

   // Fills the list to the top and works on the full list.
   task automatic test_full_list();
      logic [WORD_W-1:0] k;
      send_request(make_request(FN_CLEAR, '0, '0, 1'b0));
      while (list_count < DEPTH) begin
         do k = $urandom; while (find_in_list(k) != list_count);
         send_request(make_request(FN_APPEND, k, pick_position(), 1'($urandom)));
      end
      do k = $urandom; while (find_in_list(k) != list_count);
      send_request(make_request(FN_APPEND, k, '0, 1'b0));
      send_request(make_request(FN_APPEND, list_entries[10].key, '0, 1'b0));
      send_request(make_request(FN_READ, '0, '1, 1'b0));
      send_request(make_request(FN_SET_FLAG, '0, '1, 1'b1));
      send_request(make_request(FN_READ, '0, '1, 1'b0));
      send_request(make_request(FN_CLR_FLAGS, '0, '0, 1'b0));
      send_request(make_request(FN_READ, '0, '1, 1'b0));
      k = list_entries[20].key;
      send_request(make_request(FN_REMOVE, k, '0, 1'b0));
      send_request(make_request(FN_CONTAINS, k, '0, 1'b0));
      send_request(make_request(FN_APPEND, k, '0, 1'b0));
      send_request(make_request(FN_REMOVE, list_entries[0].key, '0, 1'b0));
      send_request(make_request(FN_REMOVE, list_entries[list_count - 1].key, '0, 1'b0));
      send_request(make_request(FN_READ, '0, 6'd0, 1'b0));
      send_request(make_request(FN_READ, '0, 6'(list_count - 1), 1'b0));
      send_request(make_request(FN_CLEAR, '0, '0, 1'b0));
   endtask

   // The receiver holds off while the sender keeps offering, so the block
   // fills up and stalls its input; then the sender waits for every response.
   task automatic test_backpressure();
      tx_idle_on = 1'b0;
      rsp_hold_request = 400;
      repeat (40) send_request(random_request());
      tx_idle_on = 1'b1;
      wait_drain();
   endtask

   // Random traffic in phases with different idling on each side.
   task automatic test_random_traffic(int n_items);
      for (int phase = 0; phase < 4; phase++) begin
         tx_idle_on = (phase == 0 || phase == 2);
         rx_idle_on = (phase == 0 || phase == 3);
         repeat (n_items / 4) send_request(random_request());
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   initial begin
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      wait_drain();
      test_full_list();
      wait_drain();
      test_backpressure();
      test_random_traffic(1200);
      wait_drain();

      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
